/* design/slpg_pkg.sv */
package slpg_pkg;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_SHORT_INTERVAL = 2'd0,
		CFG_HEARTBEAT_PAUSE = 2'd1,
		CFG_BLINK_GROUP_GAP = 2'd2
	} cfg_index_t;

	// Configuration reset values
	localparam logic [15:0] SHORT_INTERVAL_RST = 16'd100;
	localparam logic [15:0] HEARTBEAT_PAUSE_RST = 16'd700;
	localparam logic [15:0] BLINK_GROUP_GAP_RST = 16'd1000;

	// Motor state codes
	localparam logic [2:0] MS_NO_CALIB = 3'd0;
	localparam logic [2:0] MS_RUNNING = 3'd1;
	localparam logic [2:0] MS_FINISH = 3'd2;
	localparam logic [2:0] MS_STOP = 3'd3;
	localparam logic [2:0] MS_OVERLOAD = 3'd4;
	localparam logic [2:0] MS_STALL = 3'd5;

	// Heartbeat phase codes: on, off, on, long pause
	localparam logic [1:0] HB_PHASE_ONE = 2'd0;
	localparam logic [1:0] HB_PHASE_TWO = 2'd1;
	localparam logic [1:0] HB_PHASE_FOUR = 2'd3;

	// Saturation limit of the blink counter
	localparam logic [1:0] BLINK_MAX = 2'd3;

	// Blink sequencer: short on, short off, group gap
	typedef enum logic [2:0] {
		BL_ON = 3'b001,
		BL_OFF = 3'b010,
		BL_GAP = 3'b100
	} blink_phase_t;

	typedef struct packed {
		logic [15:0] elapsed_ms;
		logic [2:0] motor_state;
	} in_item_t;

	typedef struct packed {
		logic led_status_level;
		logic led_code_level;
	} out_item_t;

	typedef struct packed {
		logic [15:0] short_interval_ms;
		logic [15:0] heartbeat_pause_ms;
		logic [15:0] blink_group_gap_ms;
	} cfg_t;

	typedef struct packed {
		logic [31:0] ms_clock;
		logic [31:0] heartbeat_stamp;
		logic [1:0] heartbeat_phase;
		logic [31:0] blink_stamp;
		blink_phase_t blink_phase;
		logic [1:0] blinks_done;
		logic status_led;
		logic code_led;
	} state_t;

endpackage

/* design/slpg_cfg.sv */
module slpg_cfg import slpg_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [1:0] wr_index,
	input logic [15:0] wr_data,
	output cfg_t cfg
);

	cfg_t cfg_q;

	// Register file; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_interval_ms <= SHORT_INTERVAL_RST;
			cfg_q.heartbeat_pause_ms <= HEARTBEAT_PAUSE_RST;
			cfg_q.blink_group_gap_ms <= BLINK_GROUP_GAP_RST;
		end else if (wr_en) begin
			case (wr_index)
				CFG_SHORT_INTERVAL: cfg_q.short_interval_ms <= wr_data;
				CFG_HEARTBEAT_PAUSE: cfg_q.heartbeat_pause_ms <= wr_data;
				CFG_BLINK_GROUP_GAP: cfg_q.blink_group_gap_ms <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* design/slpg_step.sv */
module slpg_step import slpg_pkg::*; (
	input in_item_t item,
	input cfg_t cfg,
	input state_t st,
	output state_t st_next,
	output out_item_t res
);

	logic [31:0] clk_new;
	logic enable;
	logic heartbeat;
	logic [1:0] target;
	logic [15:0] hb_limit;
	logic hb_passed;
	logic bl_short_passed;
	logic bl_gap_passed;
	logic [1:0] done_inc;

	// Advance the wrapping millisecond clock
	assign clk_new = st.ms_clock + {16'd0, item.elapsed_ms};

	// Interval tests: (clock - stamp) mod 2^32 strictly above the interval
	assign hb_limit = (st.heartbeat_phase == HB_PHASE_FOUR) ? cfg.heartbeat_pause_ms
		: cfg.short_interval_ms;
	assign hb_passed = (clk_new - st.heartbeat_stamp) > {16'd0, hb_limit};
	assign bl_short_passed = (clk_new - st.blink_stamp) > {16'd0, cfg.short_interval_ms};
	assign bl_gap_passed = (clk_new - st.blink_stamp) > {16'd0, cfg.blink_group_gap_ms};
	assign done_inc = (st.blinks_done != BLINK_MAX) ? st.blinks_done + 2'd1 : st.blinks_done;

	// Motor state decode: LED0 enable, heartbeat, blink count
	always_comb begin
		enable = 1'b0;
		heartbeat = 1'b0;
		target = 2'd0;
		case (item.motor_state)
			MS_NO_CALIB: target = 2'd1;
			MS_RUNNING: begin
				enable = 1'b1;
				heartbeat = 1'b1;
			end
			MS_FINISH: enable = 1'b1;
			MS_OVERLOAD: begin
				enable = 1'b1;
				target = 2'd3;
			end
			MS_STALL: target = 2'd2;
			default: ;
		endcase
	end

	// Next state for both LEDs
	always_comb begin
		st_next = st;
		st_next.ms_clock = clk_new;

		// LED0
		if (enable) begin
			if (heartbeat) begin
				if (hb_passed) begin
					st_next.status_led = st.heartbeat_phase[0];
					st_next.heartbeat_stamp = clk_new;
					st_next.heartbeat_phase = st.heartbeat_phase + 2'd1;
				end
			end else begin
				st_next.status_led = 1'b1;
				st_next.heartbeat_phase = HB_PHASE_ONE;
			end
		end else begin
			st_next.status_led = 1'b0;
		end

		// LED1
		case (st.blink_phase)
			BL_ON: begin
				if (bl_short_passed) begin
					st_next.code_led = 1'b0;
					st_next.blink_stamp = clk_new;
					st_next.blink_phase = BL_OFF;
				end
			end
			BL_OFF: begin
				if (bl_short_passed) begin
					st_next.blinks_done = done_inc;
					st_next.blink_stamp = clk_new;
					if (target > done_inc) begin
						st_next.code_led = 1'b1;
						st_next.blink_phase = BL_ON;
					end else begin
						st_next.code_led = 1'b0;
						st_next.blink_phase = BL_GAP;
					end
				end
			end
			default: begin
				if (bl_gap_passed) begin
					st_next.blinks_done = 2'd0;
					st_next.code_led = (target != 2'd0);
					st_next.blink_stamp = clk_new;
					st_next.blink_phase = BL_ON;
				end
			end
		endcase
	end

	assign res.led_status_level = st_next.status_led;
	assign res.led_code_level = st_next.code_led;

endmodule

/* design/status_led_pattern_generator_core.sv */
// Path: an accepted item passes through the input register and then the result register.
// Throughput: one item per cycle unless out_stall holds the result register; the LED
// state is updated in the same cycle that writes the result register, so the next item
// sees it at once. Reset: arst_n clears the millisecond clock, stamps, phases and both
// LEDs, and loads the interval registers with 100, 700 and 1000 ms. Configuration writes
// are always accepted, since cfg_ready is tied high.
module status_led_pattern_generator_core import slpg_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input in_item_t in_item,
	output logic out_valid,
	input logic out_stall,
	output out_item_t out_item,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data
);

	logic valid_s1;
	in_item_t item_s1;
	logic out_valid_q;
	out_item_t out_item_q;
	state_t st_q;
	state_t st_next;
	out_item_t res;
	cfg_t cfg;
	logic out_free;
	logic fire;

	assign cfg_ready = 1'b1;

	slpg_cfg u_cfg (
		.clk (clk),
		.arst_n (arst_n),
		.wr_en (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data (cfg_data),
		.cfg (cfg)
	);

	slpg_step u_step (
		.item (item_s1),
		.cfg (cfg),
		.st (st_q),
		.st_next (st_next),
		.res (res)
	);

	// Handshake: result register frees up when empty or taken
	assign out_free = !out_valid_q || !out_stall;
	assign fire = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

	// LED state, updated once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.ms_clock <= 32'd0;
			st_q.heartbeat_stamp <= 32'd0;
			st_q.heartbeat_phase <= HB_PHASE_ONE;
			st_q.blink_stamp <= 32'd0;
			st_q.blink_phase <= BL_ON;
			st_q.blinks_done <= 2'd0;
			st_q.status_led <= 1'b0;
			st_q.code_led <= 1'b0;
		end else if (fire) begin
			st_q <= st_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_item_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

	// The clock advances by exactly the elapsed time of each item
	a_clock_adv: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> st_q.ms_clock == $past(st_q.ms_clock) + {16'd0, $past(item_s1.elapsed_ms)})
		else $error("ms clock did not advance by elapsed time");

	// State only moves when an item is processed
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(st_q))
		else $error("LED state changed without an item");

	// Stop code forces LED0 off
	a_stop_off: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item_s1.motor_state == MS_STOP) |=> !out_item_q.led_status_level)
		else $error("LED0 on in stop state");

	// Finish and overload hold LED0 on
	a_steady_on: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (item_s1.motor_state == MS_FINISH || item_s1.motor_state == MS_OVERLOAD))
		|=> out_item_q.led_status_level && st_q.heartbeat_phase == HB_PHASE_ONE)
		else $error("LED0 not steady on");

	// Input side stalls only while an item is held
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a held item");

endmodule
